FILE: sv/cta_pkg.sv
// shared types and constants of the context tagged address filter
`timescale 1ns / 1ps

package cta_pkg;

  // table geometry
  localparam int INDEX_BITS = 12;
  localparam int KIND_BITS  = 2;
  localparam int ADDR_W     = 32;
  localparam int CTX_W      = 32;
  localparam int TAG_BITS   = ADDR_W - INDEX_BITS;
  localparam int DEPTH      = 1 << INDEX_BITS;
  localparam int PTR_W      = INDEX_BITS + 1;

  // stream field widths
  localparam int CMD_W     = 2;
  localparam int KIND_IN_W = 2;
  localparam int IN_BITS   = ADDR_W + KIND_IN_W + CTX_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 3;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_FLUSH,
    ST_DONE
  } state_e;

  // one slot of the table
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [TAG_BITS-1:0]  tag;
    logic [CTX_W-1:0]     ctx;
  } entry_t;

  // decoded input item
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [ADDR_W-1:0]    addr;
    logic [KIND_IN_W-1:0] kind;
    logic [CTX_W-1:0]     ctx;
  } req_t;

  // memory access request
  typedef struct packed {
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_idx;
    entry_t                wr_data;
    logic                  rd_en;
    logic [INDEX_BITS-1:0] rd_idx;
  } mem_req_t;

  // result handed to the output register
  typedef struct packed {
    logic valid;
    logic hit;
    logic inserted;
    logic flush_done;
  } res_t;

endpackage

FILE: sv/cta_table.sv
// slot memory: one write port, one read port with registered data
`timescale 1ns / 1ps

module cta_table (
  input  logic             clk_i,
  input  cta_pkg::mem_req_t req_i,
  output cta_pkg::entry_t  rd_data_o
);
  import cta_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_idx] <= req_i.wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_idx];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/cta_ctrl.sv
// sequencer: clearing pass, lookup/insert read-modify-write and flush walk
`timescale 1ns / 1ps

module cta_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cta_pkg::req_t     req_i,
  input  logic              out_free_i,
  output cta_pkg::res_t     res_o,
  output cta_pkg::mem_req_t mem_o,
  input  cta_pkg::entry_t   rd_data_i
);
  import cta_pkg::*;

  state_e state_q, state_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic chk_q, chk_d;
  logic [INDEX_BITS-1:0] widx_q, widx_d;

  // request held for the duration of the item
  logic [CMD_W-1:0]      cmd_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [KIND_BITS-1:0]  kind_q;
  logic [CTX_W-1:0]      ctx_q;

  logic accept;
  logic kind_ok;
  logic hit;
  logic ins;
  logic flush_match;

  assign accept = in_valid_i && in_ready_o;

  // compare the slot read back with the held request
  assign kind_ok     = (kind_q != '0);
  assign hit         = (cmd_q == CMD_LOOKUP) && kind_ok && (rd_data_i.kind == kind_q) &&
                       (rd_data_i.ctx == ctx_q) && (rd_data_i.tag == tag_q);
  assign ins         = (cmd_q == CMD_INSERT) && kind_ok && (rd_data_i.kind == '0);
  assign flush_match = chk_q && (rd_data_i.kind != '0) && (rd_data_i.ctx == ctx_q);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      chk_q   <= chk_d;
    end
  end

  // request and write-back index capture
  always_ff @(posedge clk_i) begin
    widx_q <= widx_d;
    if (accept) begin
      cmd_q  <= req_i.cmd;
      idx_q  <= req_i.addr[INDEX_BITS-1:0];
      tag_q  <= req_i.addr[ADDR_W-1:INDEX_BITS];
      kind_q <= KIND_BITS'(req_i.kind);
      ctx_q  <= req_i.ctx;
    end
  end

  // next state, memory port and result
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    chk_d      = 1'b0;
    widx_d     = widx_q;
    in_ready_o = 1'b0;
    res_o      = '0;
    mem_o      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_o.wr_en  = 1'b1;
        mem_o.wr_idx = ptr_q[INDEX_BITS-1:0];
        ptr_d        = ptr_q + PTR_W'(1);
        if (ptr_q == PTR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        mem_o.rd_idx = req_i.addr[INDEX_BITS-1:0];
        if (in_valid_i) begin
          if (req_i.cmd == CMD_FLUSH) begin
            ptr_d   = '0;
            state_d = ST_FLUSH;
          end else begin
            mem_o.rd_en = 1'b1;
            state_d     = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        if (out_free_i) begin
          res_o.valid         = 1'b1;
          res_o.hit           = hit;
          res_o.inserted      = ins;
          mem_o.wr_en         = ins;
          mem_o.wr_idx        = idx_q;
          mem_o.wr_data.kind  = kind_q;
          mem_o.wr_data.tag   = tag_q;
          mem_o.wr_data.ctx   = ctx_q;
          state_d             = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        // read slot ptr while clearing the previously read slot if it holds an entry of the held context
        mem_o.rd_en  = !ptr_q[INDEX_BITS];
        mem_o.rd_idx = ptr_q[INDEX_BITS-1:0];
        mem_o.wr_en  = flush_match;
        mem_o.wr_idx = widx_q;
        chk_d        = !ptr_q[INDEX_BITS];
        widx_d       = ptr_q[INDEX_BITS-1:0];
        if (!ptr_q[INDEX_BITS]) begin
          ptr_d = ptr_q + PTR_W'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          res_o.valid      = 1'b1;
          res_o.flush_done = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        ptr_d   = '0;
      end
    endcase
  end

endmodule

FILE: sv/context_tagged_address_filter.sv
// top level of the context tagged address filter
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid_i/tready_o      tuser: command; tdata: address, kind, context
//  m_axis    out  m_axis_tvalid_o/tready_i      tdata: hit, inserted, flush_done
//
// lookup and insert each do one slot read, then compare and write-back
// flush walks the whole table with one slot read per cycle on the memory port
// after reset the table is zeroed one slot per cycle, ready held low
// a waiting result does not block acceptance; a new result waits for the output register
`timescale 1ns / 1ps

module context_tagged_address_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // command [1:0]
  input  logic [cta_pkg::CMD_W-1:0]     s_axis_tuser_i,
  // address [31:0], entry_kind [33:32], context_id [65:34], zero padding above
  input  logic [cta_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // hit [0], inserted [1], flush_done [2], zero padding above
  output logic [cta_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import cta_pkg::*;

  req_t     req;
  res_t     res;
  mem_req_t mem_req;
  entry_t   rd_data;
  logic     out_free;
  logic     out_valid_q;
  logic [OUT_BITS-1:0] out_data_q;

  // unpack the input item
  assign req.cmd  = s_axis_tuser_i;
  assign req.addr = s_axis_tdata_i[ADDR_W-1:0];
  assign req.kind = s_axis_tdata_i[ADDR_W+KIND_IN_W-1:ADDR_W];
  assign req.ctx  = s_axis_tdata_i[IN_BITS-1:ADDR_W+KIND_IN_W];

  assign out_free = !out_valid_q || m_axis_tready_i;

  cta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .req_i      (req),
    .out_free_i (out_free),
    .res_o      (res),
    .mem_o      (mem_req),
    .rd_data_i  (rd_data)
  );

  cta_table u_table (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= {res.flush_done, res.inserted, res.hit};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = M_TDATA_W'(out_data_q);

endmodule

FILE: sv/cta_checker.sv
// port-level checks of the context tagged address filter, bound to the top level
`timescale 1ns / 1ps

module cta_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [cta_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // a result flags at most one outcome
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $countones(m_axis_tdata_o) <= 1)
    else $error("result carries more than one flag");

  // one item at a time: accept drops ready
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item accepted while busy");

  // a new result only appears while an item was in work
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result without an item in work");

endmodule

bind context_tagged_address_filter cta_checker u_cta_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
